// ----- rtl/core/btlv_pkg.sv -----
// Shared types and constants for the BER-TLV stream parser.
// No dependencies; imported by btlv_step and ber_tlv_stream_parser.
`default_nettype none

package btlv_pkg;

	typedef enum logic [2:0] {
		PH_TAG_FIRST = 3'd0,
		PH_TAG_CONT  = 3'd1,
		PH_LEN_FIRST = 3'd2,
		PH_LEN_MORE  = 3'd3,
		PH_VALUE     = 3'd4,
		PH_DISCARD   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_TAG      = 3'd1,
		ERR_INDEF    = 3'd2,
		ERR_LENCOUNT = 3'd3,
		ERR_LENTRUNC = 3'd4,
		ERR_VALTRUNC = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		KIND_TAG     = 2'd0,
		KIND_LEN     = 2'd1,
		KIND_VALUE   = 2'd2,
		KIND_DISCARD = 2'd3
	} kind_t;

	localparam logic [7:0] TAG_MULTI_MASK = 8'h1F;
	localparam logic [7:0] LEN_INDEF      = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  byte_out;
		logic        tag_start;
		logic        length_done;
		logic [31:0] element_length;
		logic        element_end;
		logic [2:0]  error_code;
	} out_t;

endpackage

`default_nettype wire

// ----- rtl/core/btlv_step.sv -----
// Per-byte decode: next parser state and the result beat for one input byte.
// Depends on btlv_pkg. Purely combinational.
`default_nettype none

module btlv_step #(
	parameter int MAX_LENGTH_BYTES = 4,
	parameter int LW = $clog2(MAX_LENGTH_BYTES + 1)
) (
	input  btlv_pkg::in_t    item,
	input  btlv_pkg::phase_t phase,
	input  logic [LW-1:0]    len_left,
	input  logic [31:0]      len_acc,
	input  logic [31:0]      val_left,
	output btlv_pkg::phase_t phase_nxt,
	output logic [LW-1:0]    len_left_nxt,
	output logic [31:0]      len_acc_nxt,
	output logic [31:0]      val_left_nxt,
	output btlv_pkg::out_t   res
);
	import btlv_pkg::*;

	logic [7:0]    b;
	logic          eom;
	logic          complete;
	logic [31:0]   len;
	logic [31:0]   acc_new;
	logic [LW-1:0] left_dec;
	logic [31:0]   val_dec;
	logic [6:0]    n;

	assign b   = item.data_byte;
	assign eom = item.end_of_message;
	assign n   = b[6:0];

	always_comb begin
		res            = '0;
		res.byte_out   = b;
		phase_nxt      = phase;
		len_left_nxt   = len_left;
		len_acc_nxt    = len_acc;
		val_left_nxt   = val_left;
		complete       = 1'b0;
		len            = '0;
		acc_new        = (len_acc[31:24] != 8'd0) ? 32'hFFFF_FFFF : {len_acc[23:0], b};
		left_dec       = (len_left != '0) ? len_left - LW'(1) : len_left;
		val_dec        = (val_left != 32'd0) ? val_left - 32'd1 : val_left;

		unique case (phase)
			PH_TAG_FIRST: begin
				res.byte_kind = KIND_TAG;
				res.tag_start = 1'b1;
				if ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK) begin
					phase_nxt = PH_TAG_CONT;
					if (eom) begin
						res.error_code = ERR_TAG;
						phase_nxt      = PH_TAG_FIRST;
					end
				end else begin
					phase_nxt = PH_LEN_FIRST;
					if (eom) begin
						res.error_code = ERR_LENTRUNC;
						phase_nxt      = PH_TAG_FIRST;
					end
				end
			end
			PH_TAG_CONT: begin
				res.byte_kind = KIND_TAG;
				if (b[7]) begin
					if (eom) begin
						res.error_code = ERR_TAG;
						phase_nxt      = PH_TAG_FIRST;
					end
				end else begin
					phase_nxt = PH_LEN_FIRST;
					if (eom) begin
						res.error_code = ERR_LENTRUNC;
						phase_nxt      = PH_TAG_FIRST;
					end
				end
			end
			PH_LEN_FIRST: begin
				res.byte_kind = KIND_LEN;
				if (!b[7]) begin
					complete = 1'b1;
					len      = {24'd0, b};
				end else if (b == LEN_INDEF) begin
					res.error_code = ERR_INDEF;
					phase_nxt      = eom ? PH_TAG_FIRST : PH_DISCARD;
				end else if (n > 7'(MAX_LENGTH_BYTES)) begin
					res.error_code = ERR_LENCOUNT;
					phase_nxt      = eom ? PH_TAG_FIRST : PH_DISCARD;
				end else begin
					len_left_nxt = n[LW-1:0];
					len_acc_nxt  = '0;
					phase_nxt    = PH_LEN_MORE;
					if (eom) begin
						res.error_code = ERR_LENTRUNC;
						phase_nxt      = PH_TAG_FIRST;
					end
				end
			end
			PH_LEN_MORE: begin
				res.byte_kind = KIND_LEN;
				len_acc_nxt   = acc_new;
				len_left_nxt  = left_dec;
				if (left_dec == '0) begin
					complete = 1'b1;
					len      = acc_new;
				end else if (eom) begin
					res.error_code = ERR_LENTRUNC;
					phase_nxt      = PH_TAG_FIRST;
				end
			end
			PH_VALUE: begin
				res.byte_kind = KIND_VALUE;
				val_left_nxt  = val_dec;
				if (val_dec == 32'd0) begin
					res.element_end = 1'b1;
					phase_nxt       = PH_TAG_FIRST;
				end else if (eom) begin
					res.error_code = ERR_VALTRUNC;
					phase_nxt      = PH_TAG_FIRST;
				end
			end
			default: begin
				res.byte_kind = KIND_DISCARD;
				phase_nxt     = eom ? PH_TAG_FIRST : PH_DISCARD;
			end
		endcase

		// length field finished: zero length closes the element on this byte
		if (complete) begin
			res.length_done    = 1'b1;
			res.element_length = len;
			if (len == 32'd0) begin
				res.element_end = 1'b1;
				phase_nxt       = PH_TAG_FIRST;
			end else if (eom) begin
				res.error_code = ERR_VALTRUNC;
				phase_nxt      = PH_TAG_FIRST;
			end else begin
				val_left_nxt = len;
				phase_nxt    = PH_VALUE;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ber_tlv_stream_parser.sv -----
// BER-TLV stream parser top level: input register, decode, result register.
// Depends on btlv_pkg and btlv_step.
//
// Splits a byte stream into BER-TLV elements, labeling each byte as tag,
// length, value or discarded, and flagging tag start, length completion,
// element end and errors on the byte where they are found. One byte is
// accepted every cycle while data_stall is low. A byte's result beat goes
// from the input register into the result register, and is offered on
// result_valid while it sits there. The rate of one byte per cycle holds
// because the per-byte state update is combinational between the state
// registers; its longest path is the 32-bit value-byte counter decrement
// and zero compare.
// The input stalls only when both the input and result registers hold beats
// and the result side is stalled. There is no clearing pass after reset.
`default_nettype none

module ber_tlv_stream_parser #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           data_valid,
	output logic           data_stall,
	input  btlv_pkg::in_t  data,
	output logic           result_valid,
	input  logic           result_stall,
	output btlv_pkg::out_t result
);
	import btlv_pkg::*;

	localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

	logic          vld_s1;
	in_t           item_s1;
	logic          vld_s2;
	out_t          res_s2;
	logic          adv;

	phase_t        phase_q, phase_nxt;
	logic [LW-1:0] len_left_q, len_left_nxt;
	logic [31:0]   len_acc_q, len_acc_nxt;
	logic [31:0]   val_left_q, val_left_nxt;
	out_t          res_nxt;

	assign adv          = vld_s1 && (!vld_s2 || !result_stall);
	assign data_stall   = vld_s1 && vld_s2 && result_stall;
	assign result_valid = vld_s2;
	assign result       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!data_stall) begin
			vld_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			item_s1 <= data;
		end
	end

	btlv_step #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
		.LW(LW)
	) u_step (
		.item        (item_s1),
		.phase       (phase_q),
		.len_left    (len_left_q),
		.len_acc     (len_acc_q),
		.val_left    (val_left_q),
		.phase_nxt   (phase_nxt),
		.len_left_nxt(len_left_nxt),
		.len_acc_nxt (len_acc_nxt),
		.val_left_nxt(val_left_nxt),
		.res         (res_nxt)
	);

	// parser state moves only when the beat in s1 moves on to s2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			len_left_q <= '0;
			len_acc_q  <= '0;
			val_left_q <= '0;
		end else if (adv) begin
			phase_q    <= phase_nxt;
			len_left_q <= len_left_nxt;
			len_acc_q  <= len_acc_nxt;
			val_left_q <= val_left_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || !result_stall) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> vld_s1)
		else $error("input stalled with empty input register");

	a_eom_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.end_of_message) |=> (phase_q == PH_TAG_FIRST))
		else $error("parser not back at tag start after end of message");

	a_value_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VALUE) |-> (val_left_q != 32'd0))
		else $error("value phase with no value bytes owed");

	a_len_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEN_MORE) |-> (len_left_q != '0))
		else $error("long length phase with no length bytes owed");

endmodule

`default_nettype wire
